// ===== rtl/core/wmpc_pkg.sv =====
// Package for the module policy checker: phases, verdict codes, register indexes
// and the front-to-back queue entry. No dependencies.
`default_nettype none
package wmpc_pkg;
  typedef enum logic [1:0] {PH_HEADER, PH_SEC_ID, PH_SEC_SIZE, PH_SEC_BODY} phase_t;

  localparam logic [4:0] V_OK = 5'd0;
  localparam logic [4:0] V_SIZE = 5'd1;
  localparam logic [4:0] V_SHORT = 5'd2;
  localparam logic [4:0] V_HEADER = 5'd3;
  localparam logic [4:0] V_TRUNC = 5'd4;
  localparam logic [4:0] V_LEB_OVF = 5'd5;
  localparam logic [4:0] V_LEB_LONG = 5'd6;
  localparam logic [4:0] V_DUP_IMPORT = 5'd7;
  localparam logic [4:0] V_IMPORT_CNT = 5'd8;
  localparam logic [4:0] V_IMPORT_TRAIL = 5'd9;
  localparam logic [4:0] V_DUP_MEM = 5'd10;
  localparam logic [4:0] V_MEM_CNT = 5'd11;
  localparam logic [4:0] V_MEM_FLAGS = 5'd12;
  localparam logic [4:0] V_MEM_LIMITS = 5'd13;
  localparam logic [4:0] V_MEM_TRAIL = 5'd14;
  localparam logic [4:0] V_START = 5'd15;
  localparam logic [4:0] V_NO_MEM = 5'd16;

  localparam logic [7:0] SEC_IMPORT = 8'd2;
  localparam logic [7:0] SEC_MEMORY = 8'd5;
  localparam logic [7:0] SEC_START = 8'd8;

  localparam logic [0:0] REG_SIZE_LIMIT = 1'b0;
  localparam logic [0:0] REG_PAGE_CAP = 1'b1;

  localparam logic [32:0] BYTES_MAX = 33'h1_FFFF_FFFF;

  function automatic logic [7:0] hdr_byte(input logic [2:0] i);
    case (i)
      3'd1: hdr_byte = 8'h61;
      3'd2: hdr_byte = 8'h73;
      3'd3: hdr_byte = 8'h6d;
      3'd4: hdr_byte = 8'h01;
      default: hdr_byte = 8'h00;
    endcase
  endfunction

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       size_over;
  } qent_t;
endpackage
`default_nettype wire

// ===== rtl/core/wmpc_front.sv =====
// Front: accepts bytes, counts module length and flags the size-over-limit case.
// Depends on wmpc_pkg.
`default_nettype none
module wmpc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_module_byte,
  input  wire logic           in_final_byte,
  input  wire logic [31:0]    size_limit,
  output wmpc_pkg::qent_t     q_data,
  output logic                q_valid,
  input  wire logic           q_full
);
  import wmpc_pkg::*;
  logic [32:0] bytes_r, bytes_nxt;
  logic        acc;

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;

  always_comb begin
    bytes_nxt = bytes_r;
    if (bytes_r != BYTES_MAX) bytes_nxt = bytes_r + 33'd1;
  end

  assign q_valid = acc;
  assign q_data.data = in_module_byte;
  assign q_data.last = in_final_byte;
  assign q_data.size_over = bytes_nxt > {1'b0, size_limit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
    end else if (acc) begin
      bytes_r <= in_final_byte ? 33'd0 : bytes_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/wmpc_queue.sv =====
// Two-entry queue between front and back.
// Depends on wmpc_pkg.
`default_nettype none
module wmpc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  input  wmpc_pkg::qent_t     wr_data,
  output logic                full,
  output logic                rd_valid,
  output wmpc_pkg::qent_t     rd_data,
  input  wire logic           rd_pop
);
  import wmpc_pkg::*;
  qent_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid) wp_r <= !wp_r;
      if (rd_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid} - {1'b0, rd_pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/wmpc_back.sv =====
// Back: header check, section walk, LEB decode and verdict register.
// Depends on wmpc_pkg.
`default_nettype none
module wmpc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wmpc_pkg::qent_t     q_data,
  output logic                q_pop,
  input  wire logic [16:0]    page_cap,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [4:0]          out_verdict
);
  import wmpc_pkg::*;
  phase_t      ph_r, ph_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  sid_r, sid_nxt;
  logic [31:0] left_r, left_nxt;
  logic [34:0] acc_r, acc_nxt;
  logic [2:0]  li_r, li_nxt;
  logic [2:0]  fi_r, fi_nxt;
  logic [31:0] low_r, low_nxt;
  logic        imp_r, imp_nxt, mem_r, mem_nxt;
  logic [4:0]  pf_r, pf_nxt, lf_r, lf_nxt;
  logic        ov_r;
  logic [4:0]  v_r, verdict;
  logic        go;
  logic [7:0]  b;
  logic [34:0] lacc;
  logic        ldone;
  logic [2:0]  linc;
  logic [31:0] lval;

  assign go = q_valid && (!ov_r || out_ready);
  assign q_pop = go;
  assign b = q_data.data;
  assign out_valid = ov_r;
  assign out_verdict = v_r;

  always_comb begin
    lacc = acc_r | ({28'd0, b[6:0]} << ({3'd0, li_r} * 6'd7));
    ldone = !b[7];
    linc = li_r + 3'd1;
    lval = lacc[31:0];
  end

  always_comb begin
    logic endsec;
    ph_nxt = ph_r; pos_nxt = pos_r; sid_nxt = sid_r; left_nxt = left_r;
    acc_nxt = acc_r; li_nxt = li_r; fi_nxt = fi_r; low_nxt = low_r;
    imp_nxt = imp_r; mem_nxt = mem_r; pf_nxt = pf_r; lf_nxt = lf_r;
    endsec = 1'b0;
    if (pos_r != 3'd7 || ph_r != PH_HEADER) pos_nxt = pos_r + 3'd1;
    if (lf_r == V_OK) begin
      case (ph_r)
        PH_HEADER: begin
          if (b != hdr_byte(pos_r)) lf_nxt = V_HEADER;
          else if (pos_r == 3'd7) ph_nxt = PH_SEC_ID;
        end
        PH_SEC_ID: begin
          sid_nxt = b; acc_nxt = '0; li_nxt = '0; ph_nxt = PH_SEC_SIZE;
        end
        PH_SEC_SIZE: begin
          acc_nxt = lacc;
          if (ldone) begin
            if (lacc[34:32] != 3'd0) lf_nxt = V_LEB_OVF;
            else begin
              left_nxt = lval; pf_nxt = V_OK; fi_nxt = '0;
              acc_nxt = '0; li_nxt = '0; ph_nxt = PH_SEC_BODY;
              if (sid_r == SEC_IMPORT) begin
                if (imp_r) pf_nxt = V_DUP_IMPORT; else imp_nxt = 1'b1;
              end else if (sid_r == SEC_MEMORY) begin
                if (mem_r) pf_nxt = V_DUP_MEM; else mem_nxt = 1'b1;
              end else if (sid_r == SEC_START) pf_nxt = V_START;
              endsec = lval == 32'd0;
            end
          end else begin
            li_nxt = linc;
            if (linc == 3'd5) lf_nxt = V_LEB_LONG;
          end
        end
        default: begin
          if (left_r != 32'd0) left_nxt = left_r - 32'd1;
          if (pf_r == V_OK) begin
            if (sid_r == SEC_IMPORT && fi_r >= 3'd1) pf_nxt = V_IMPORT_TRAIL;
            else if (sid_r == SEC_MEMORY && fi_r >= 3'd4) pf_nxt = V_MEM_TRAIL;
            else if (sid_r == SEC_IMPORT || sid_r == SEC_MEMORY) begin
              acc_nxt = lacc;
              if (!ldone) begin
                li_nxt = linc;
                if (linc == 3'd5) pf_nxt = V_LEB_LONG;
              end else if (lacc[34:32] != 3'd0) pf_nxt = V_LEB_OVF;
              else begin
                acc_nxt = '0; li_nxt = '0; fi_nxt = fi_r + 3'd1;
                if (sid_r == SEC_IMPORT) begin
                  if (lval != 32'd0) pf_nxt = V_IMPORT_CNT;
                end else if (fi_r == 3'd0) begin
                  if (lval != 32'd1) pf_nxt = V_MEM_CNT;
                end else if (fi_r == 3'd1) begin
                  if (lval != 32'd1) pf_nxt = V_MEM_FLAGS;
                end else if (fi_r == 3'd2) low_nxt = lval;
                else if (lval < low_r || low_r > {15'd0, page_cap} ||
                         lval > {15'd0, page_cap}) pf_nxt = V_MEM_LIMITS;
              end
            end
          end
          endsec = left_nxt == 32'd0;
        end
      endcase
      if (endsec) begin
        if (pf_nxt == V_OK && ((sid_r == SEC_IMPORT && fi_nxt < 3'd1) ||
            (sid_r == SEC_MEMORY && fi_nxt < 3'd4))) pf_nxt = V_TRUNC;
        if (pf_nxt != V_OK) lf_nxt = pf_nxt;
        pf_nxt = V_OK; acc_nxt = '0; li_nxt = '0; fi_nxt = '0; ph_nxt = PH_SEC_ID;
      end
    end
  end

  always_comb begin
    if (q_data.size_over) verdict = V_SIZE;
    else if (pos_r != 3'd7 && ph_r == PH_HEADER) verdict = V_SHORT;
    else if (lf_nxt != V_OK) verdict = lf_nxt;
    else if (ph_nxt != PH_SEC_ID) verdict = V_TRUNC;
    else if (!mem_nxt) verdict = V_NO_MEM;
    else verdict = V_OK;
  end

  always_ff @(posedge clk) begin
    if (go && q_data.last) v_r <= verdict;
    if (go) begin
      sid_r <= sid_nxt; left_r <= left_nxt; acc_r <= acc_nxt; low_r <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      ph_r <= PH_HEADER; pos_r <= '0; li_r <= '0; fi_r <= '0;
      imp_r <= 1'b0; mem_r <= 1'b0; pf_r <= V_OK; lf_r <= V_OK;
    end else begin
      if (go) ov_r <= q_data.last;
      else if (out_ready) ov_r <= 1'b0;
      if (go) begin
        if (q_data.last) begin
          ph_r <= PH_HEADER; pos_r <= '0; li_r <= '0; fi_r <= '0;
          imp_r <= 1'b0; mem_r <= 1'b0; pf_r <= V_OK; lf_r <= V_OK;
        end else begin
          ph_r <= ph_nxt; pos_r <= pos_nxt; li_r <= li_nxt; fi_r <= fi_nxt;
          imp_r <= imp_nxt; mem_r <= mem_nxt; pf_r <= pf_nxt; lf_r <= lf_nxt;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/wasm_module_policy_checker.sv =====
// Top level of the module policy checker: configuration registers, front, queue, back.
// Depends on wmpc_pkg, wmpc_front, wmpc_queue, wmpc_back.
//
// Takes one module byte per cycle while in_ready is high (low when the queue is full)
// and gives one verdict on the byte marked final, through the front-to-back queue and
// the verdict register. The user must write configuration only while no module is in
// flight; the block itself does not enforce this.
`default_nettype none
module wasm_module_policy_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_module_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_verdict,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import wmpc_pkg::*;
  logic [31:0] limit_r;
  logic [16:0] cap_r;
  qent_t       wq, rq;
  logic        wv, full, rv, pop;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 32'd1048576;
      cap_r <= 17'd16;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SIZE_LIMIT) limit_r <= cfg_data;
      else if (cfg_index == REG_PAGE_CAP) cap_r <= cfg_data[16:0];
    end
  end

  wmpc_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_module_byte,
    .in_final_byte, .size_limit(limit_r), .q_data(wq), .q_valid(wv), .q_full(full));
  wmpc_queue u_queue (.clk, .rst_n, .wr_valid(wv), .wr_data(wq), .full,
    .rd_valid(rv), .rd_data(rq), .rd_pop(pop));
  wmpc_back u_back (.clk, .rst_n, .q_valid(rv), .q_data(rq), .q_pop(pop),
    .page_cap(cap_r), .out_valid, .out_ready, .out_verdict);
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for wasm_module_policy_checker: streams module bytes, predicts each verdict
// in step with the input transfers and checks every output transfer. Uses wmpc_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import wmpc_pkg::*;

  localparam int LEB_MORE = 0;
  localparam int LEB_DONE = 1;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } mod_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_module_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_verdict;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_SIZE_LIMIT;
  logic [31:0] cfg_data = 32'd0;

  wasm_module_policy_checker dut (.*);

  always #5 clk = ~clk;

  mod_item_t   byte_q[$];
  logic [4:0]  verdict_q[$];
  logic [7:0]  mod_bytes[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  // predictor state
  logic [31:0] size_limit;
  logic [16:0] page_cap;
  logic [32:0] seen;
  phase_t      phase;
  logic [7:0]  sec_id;
  logic [31:0] sec_left;
  logic [34:0] acc;
  logic [2:0]  leb_idx;
  logic [2:0]  field;
  logic [31:0] low_pages;
  logic        import_done;
  logic        memory_done;
  logic [4:0]  pend;
  logic [4:0]  latch;

  logic [7:0] magic [8] = '{8'h00, 8'h61, 8'h73, 8'h6d, 8'h01, 8'h00, 8'h00, 8'h00};

  function automatic void clear_parse();
    seen = '0; phase = PH_HEADER; sec_id = '0; sec_left = '0; acc = '0; leb_idx = '0;
    field = '0; low_pages = '0; import_done = 1'b0; memory_done = 1'b0;
    pend = V_OK; latch = V_OK;
  endfunction

  function automatic int leb_step(input logic [7:0] b);
    acc = acc | ({28'd0, b[6:0]} << (7 * (leb_idx % 5)));
    if (!b[7]) return (acc > 35'hFFFF_FFFF) ? V_LEB_OVF : LEB_DONE;
    leb_idx = leb_idx + 3'd1;
    if (leb_idx >= 3'd5) return V_LEB_LONG;
    return LEB_MORE;
  endfunction

  function automatic void close_section();
    if (pend == V_OK) begin
      if (sec_id == SEC_IMPORT && field < 3'd1) pend = V_TRUNC;
      else if (sec_id == SEC_MEMORY && field < 3'd4) pend = V_TRUNC;
    end
    if (pend != V_OK) latch = pend;
    pend = V_OK; acc = '0; leb_idx = '0; field = '0; phase = PH_SEC_ID;
  endfunction

  function automatic void open_section();
    pend = V_OK; field = '0; acc = '0; leb_idx = '0;
    if (sec_id == SEC_IMPORT) begin
      if (import_done) pend = V_DUP_IMPORT; else import_done = 1'b1;
    end else if (sec_id == SEC_MEMORY) begin
      if (memory_done) pend = V_DUP_MEM; else memory_done = 1'b1;
    end else if (sec_id == SEC_START) begin
      pend = V_START;
    end
    phase = PH_SEC_BODY;
    if (sec_left == 0) close_section();
  endfunction

  function automatic void payload_byte(input logic [7:0] b);
    int r;
    logic [31:0] v;
    if (sec_id == SEC_IMPORT) begin
      if (field >= 3'd1) begin pend = V_IMPORT_TRAIL; return; end
    end else if (sec_id == SEC_MEMORY) begin
      if (field >= 3'd4) begin pend = V_MEM_TRAIL; return; end
    end else begin
      return;
    end
    r = leb_step(b);
    if (r == LEB_MORE) return;
    if (r != LEB_DONE) begin pend = 5'(r); return; end
    v = acc[31:0];
    acc = '0; leb_idx = '0;
    if (sec_id == SEC_IMPORT) begin
      if (v != 0) pend = V_IMPORT_CNT;
    end else if (field == 3'd0) begin
      if (v != 1) pend = V_MEM_CNT;
    end else if (field == 3'd1) begin
      if (v != 1) pend = V_MEM_FLAGS;
    end else if (field == 3'd2) begin
      low_pages = v;
    end else if (v < low_pages || low_pages > {15'd0, page_cap} || v > {15'd0, page_cap}) begin
      pend = V_MEM_LIMITS;
    end
    field = field + 3'd1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic [32:0] pos);
    int r;
    case (phase)
      PH_HEADER: begin
        if (b != magic[pos[2:0]]) begin latch = V_HEADER; return; end
        if (pos >= 7) phase = PH_SEC_ID;
      end
      PH_SEC_ID: begin
        sec_id = b; acc = '0; leb_idx = '0; phase = PH_SEC_SIZE;
      end
      PH_SEC_SIZE: begin
        r = leb_step(b);
        if (r == LEB_DONE) begin
          sec_left = acc[31:0];
          open_section();
        end else if (r != LEB_MORE) begin
          latch = 5'(r);
        end
      end
      default: begin
        if (sec_left > 0) sec_left = sec_left - 1;
        if (pend == V_OK) payload_byte(b);
        if (sec_left == 0) close_section();
      end
    endcase
  endfunction

  function automatic void predict_verdict(input logic [7:0] b, input logic fin);
    logic [32:0] pos;
    logic [4:0] v;
    pos = seen;
    if (seen != BYTES_MAX) seen = seen + 33'd1;
    if (latch == V_OK) parse_byte(b, pos);
    if (!fin) return;
    if (seen > {1'b0, size_limit}) v = V_SIZE;
    else if (seen < 8) v = V_SHORT;
    else if (latch != V_OK) v = latch;
    else if (phase != PH_SEC_ID) v = V_TRUNC;
    else if (!memory_done) v = V_NO_MEM;
    else v = V_OK;
    verdict_q.push_back(v);
    clear_parse();
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_verdict(in_module_byte, in_final_byte);
      if (!(in_valid && !in_ready)) begin
        if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          mod_item_t it;
          it = byte_q.pop_front();
          in_module_byte <= it.data;
          in_final_byte <= it.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected verdict: expected none got %0d", $time, out_verdict);
          errors++;
        end else begin
          logic [4:0] e;
          e = verdict_q.pop_front();
          if (out_verdict !== e) begin
            $display("%0t verdict mismatch: expected %0d got %0d", $time, e, out_verdict);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic void push_leb(input logic [31:0] v, input int pad);
    logic more;
    do begin
      more = (v >> 7) != 0 || pad > 0;
      mod_bytes.push_back({more, v[6:0]});
      v = v >> 7;
    end while ((v != 0));
    if (pad > 0) begin
      repeat (pad - 1) mod_bytes.push_back(8'h80);
      mod_bytes.push_back(8'h00);
    end
  endfunction

  function automatic void add_section(input logic [7:0] id, input logic [7:0] body[$]);
    int sz;
    int pick;
    sz = body.size();
    pick = $urandom_range(0, 99);
    mod_bytes.push_back(id);
    if (pick < 3) begin
      repeat (4) mod_bytes.push_back(8'hff);
      mod_bytes.push_back(8'h7f);
    end else if (pick < 6) begin
      repeat (5) mod_bytes.push_back(8'h80);
      mod_bytes.push_back(8'h00);
    end else begin
      if (pick < 11) sz = sz + 1;
      else if (pick < 16 && sz > 0) sz = sz - 1;
      push_leb(32'(sz), (pick >= 90) ? $urandom_range(1, 3) : 0);
    end
    foreach (body[i]) mod_bytes.push_back(body[i]);
  endfunction

  function automatic void gen_module();
    logic [7:0] body[$];
    logic [31:0] lo, hi;
    int n, kind;
    bit has_mem;
    mod_bytes.delete();
    if ($urandom_range(0, 99) < 20) begin
      n = $urandom_range(1, 12);
      repeat (n) mod_bytes.push_back(8'($urandom()));
    end else begin
      foreach (magic[i]) mod_bytes.push_back(magic[i]);
      if ($urandom_range(0, 99) < 5)
        mod_bytes[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
      has_mem = 0;
      n = $urandom_range(0, 4);
      for (int s = 0; s <= n; s++) begin
        kind = $urandom_range(0, 9);
        if (s == n) kind = (!has_mem && $urandom_range(0, 99) < 85) ? 2 : 99;
        if (kind == 99) break;
        body.delete();
        if (kind <= 1) begin
          if ($urandom_range(0, 99) < 15) body.push_back(8'($urandom_range(1, 255)) & 8'h7f);
          else body.push_back(8'h00);
          if ($urandom_range(0, 99) < 10) body.push_back(8'($urandom()));
          add_section(SEC_IMPORT, body);
        end else if (kind <= 4) begin
          has_mem = 1;
          lo = $urandom_range(0, page_cap);
          hi = $urandom_range(lo, page_cap);
          if ($urandom_range(0, 99) < 10) hi = {15'd0, page_cap} + 1;
          else if ($urandom_range(0, 99) < 8 && lo > 0) hi = lo - 1;
          else if ($urandom_range(0, 99) < 5) lo = $urandom();
          mod_bytes.push_back(SEC_MEMORY);
          begin
            int base;
            base = mod_bytes.size();
            push_leb(($urandom_range(0, 99) < 10) ? $urandom_range(0, 3) : 1, 0);
            push_leb(($urandom_range(0, 99) < 10) ? $urandom_range(2, 3) : 1, 0);
            push_leb(lo, 0);
            if ($urandom_range(0, 99) >= 5) push_leb(hi, 0);
            if ($urandom_range(0, 99) < 5) mod_bytes.push_back(8'($urandom()));
            while (mod_bytes.size() > base) body.push_front(mod_bytes.pop_back());
          end
          void'(mod_bytes.pop_back());
          add_section(SEC_MEMORY, body);
        end else if (kind == 5) begin
          add_section(SEC_START, body);
        end else begin
          logic [7:0] id;
          do id = 8'($urandom()); while (id == SEC_IMPORT || id == SEC_MEMORY || id == SEC_START);
          repeat ($urandom_range(0, 4)) body.push_back(8'($urandom()));
          add_section(id, body);
        end
      end
      if ($urandom_range(0, 99) < 10)
        while (mod_bytes.size() > 1 && $urandom_range(0, 2) != 0) void'(mod_bytes.pop_back());
    end
    foreach (mod_bytes[i]) byte_q.push_back('{mod_bytes[i], i == mod_bytes.size() - 1});
  endfunction

  function automatic void queue_bytes(input logic [7:0] b[$]);
    foreach (b[i]) byte_q.push_back('{b[i], i == b.size() - 1});
  endfunction

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SIZE_LIMIT) size_limit = data;
    else page_cap = data[16:0];
  endtask

  logic [31:0] limits [6] = '{32'd1048576, 32'd1, 32'hFFFF_FFFF, 32'd30, 32'd0, 32'd64};
  logic [31:0] caps [6] = '{32'd16, 32'd1, 32'd65536, 32'd3, 32'd0, 32'd200};

  initial begin
    size_limit = 32'd1048576;
    page_cap = 17'd16;
    clear_parse();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: minimal valid module, single byte, header only
    queue_bytes('{8'h00, 8'h61, 8'h73, 8'h6d, 8'h01, 8'h00, 8'h00, 8'h00,
                  SEC_MEMORY, 8'h04, 8'h01, 8'h01, 8'h01, 8'h10});
    queue_bytes('{8'hff});
    queue_bytes('{8'h00, 8'h61, 8'h73, 8'h6d, 8'h01, 8'h00, 8'h00, 8'h00});
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SIZE_LIMIT, limits[p]);
      write_reg(REG_PAGE_CAP, caps[p]);
      case (p % 3)
        0: begin send_idle = 36; recv_idle = 81; end
        1: begin send_idle = 81; recv_idle = 36; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      while (byte_q.size() < 60) gen_module();
      wait_drained();
      while (byte_q.size() < 60) gen_module();
      wait_drained();
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("PASS wasm_module_policy_checker");
    end else begin
      $display("FAIL wasm_module_policy_checker");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL wasm_module_policy_checker");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/wmpc_pkg.sv
rtl/core/wmpc_front.sv
rtl/core/wmpc_queue.sv
rtl/core/wmpc_back.sv
rtl/core/wasm_module_policy_checker.sv
sim/tb.sv
